// File: src/grid_flood_fill_engine_core_defines.svh
// Assertion macros of the flood fill engine, included by its top level.
`ifndef GRID_FLOOD_FILL_ENGINE_CORE_DEFINES_SVH
`define GRID_FLOOD_FILL_ENGINE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GFFE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GFFE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/gffe_pkg.sv
// Shared constants, types and helper functions of the flood fill engine.
package gffe_pkg;

   localparam int GRID_SIZE = 64;
   localparam int FIELD_W = 6;
   localparam int COLOR_W = 4;
   localparam int COUNT_W = 13;
   localparam int FUNC_W = 2;
   localparam int STATUS_W = 2;
   localparam int COORD_W = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
   localparam int ADDR_W = 2 * COORD_W;
   localparam int CELL_SPAN = 1 << ADDR_W;
   localparam int CELL_COUNT = GRID_SIZE * GRID_SIZE;
   localparam int QA_W = $clog2(CELL_COUNT);
   localparam int QC_W = $clog2(CELL_COUNT + 1);

   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FILL = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   localparam logic [1:0] DIR_LEFT = 2'd0;
   localparam logic [1:0] DIR_RIGHT = 2'd1;
   localparam logic [1:0] DIR_UP = 2'd2;
   localparam logic [1:0] DIR_DOWN = 2'd3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] x;
   } cell_type;

   typedef struct packed {
      logic     ok;
      cell_type pos;
   } nbr_type;

   typedef struct packed {
      logic                sweep;
      logic                load_req;
      logic                take_prev;
      logic                write_cell;
      logic                start_fill;
      logic                pop;
      logic                load_cur;
      logic                nbr_issue;
      logic                clean_start;
      logic                clean_rd;
      logic                rsp_load;
      logic                set_status;
      logic [STATUS_W-1:0] status;
   } cmd_type;

   typedef struct packed {
      logic              sweep_last;
      logic              in_range;
      logic [FUNC_W-1:0] func;
      logic              prev_diff;
      logic              fill_ok;
      logic              q_empty;
      logic              dir_last;
   } sts_type;

   function automatic logic [COORD_W-1:0] to_coord(logic [FIELD_W-1:0] f);
      return COORD_W'(f);
   endfunction

   function automatic nbr_type neighbor(cell_type c, logic [1:0] dir);
      nbr_type n;
      n.ok = 1'b0;
      n.pos = c;
      case (dir)
         DIR_LEFT: begin
            n.ok = (c.x != '0);
            n.pos.x = c.x - 1'b1;
         end
         DIR_RIGHT: begin
            n.ok = (int'(c.x) < GRID_SIZE - 1);
            n.pos.x = c.x + 1'b1;
         end
         DIR_UP: begin
            n.ok = (c.y != '0);
            n.pos.y = c.y - 1'b1;
         end
         DIR_DOWN: begin
            n.ok = (int'(c.y) < GRID_SIZE - 1);
            n.pos.y = c.y + 1'b1;
         end
         default: begin
            n.ok = 1'b0;
         end
      endcase
      return n;
   endfunction

endpackage

// File: src/gffe_ifs.sv
// Request and response channel interfaces of the flood fill engine.
interface gffe_req_if import gffe_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FUNC_W-1:0]  func;
   logic [FIELD_W-1:0] col_x;
   logic [FIELD_W-1:0] row_y;
   logic [COLOR_W-1:0] color;

   modport source (output valid, func, col_x, row_y, color, input ready);
   modport sink (input valid, func, col_x, row_y, color, output ready);
endinterface

interface gffe_rsp_if import gffe_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [COLOR_W-1:0]  read_color;
   logic [COUNT_W-1:0]  changed_count;
   logic [STATUS_W-1:0] status;

   modport source (output valid, read_color, changed_count, status, input ready);
   modport sink (input valid, read_color, changed_count, status, output ready);
endinterface

// File: src/grid_flood_fill_engine_core.sv
// Top level of the 4-connected flood fill engine on a 64 by 64 grid of color codes.
//
//   channel   dir   handshake            payload
//   req_bus   in    valid / ready        func, col_x, row_y, color
//   rsp_bus   out   valid / ready        read_color, changed_count, status
//
// After reset a clearing pass zeroes the grid and the visited map; no request beat is
// taken during it. Reads, writes, ignored fills and out-of-range requests go from the
// request read to the response stage. A fill works cell by cell: for each cell it pops
// the work queue, writes the color and makes four neighbor probes through the grid and
// visited RAM ports; afterwards it clears the visited map along the work queue. The
// next request beat is taken as soon as the response is loaded, while that response may
// still wait for its sink.
module grid_flood_fill_engine_core import gffe_pkg::*; (
   input logic        clock,
   input logic        reset,
   gffe_req_if.sink   req_bus,
   gffe_rsp_if.source rsp_bus
);

   `include "grid_flood_fill_engine_core_defines.svh"

   cmd_type ctrl_cmd;
   sts_type dp_sts;

   gffe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .sts       (dp_sts),
      .cmd       (ctrl_cmd),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready)
   );

   gffe_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (ctrl_cmd),
      .sts               (dp_sts),
      .req_func          (req_bus.func),
      .req_col_x         (req_bus.col_x),
      .req_row_y         (req_bus.row_y),
      .req_color         (req_bus.color),
      .rsp_read_color    (rsp_bus.read_color),
      .rsp_changed_count (rsp_bus.changed_count),
      .rsp_status        (rsp_bus.status)
   );

   `GFFE_ASSERT_SAME(a_grid_write_excl, 1'b1, $onehot0({ctrl_cmd.sweep, ctrl_cmd.write_cell, ctrl_cmd.load_cur}), "grid write port claimed twice")
   `GFFE_ASSERT_NEXT(a_busy_after_req, req_bus.valid && req_bus.ready, !req_bus.ready, "request beat taken while busy")
   `GFFE_ASSERT_SAME(a_range_clean, rsp_bus.valid && rsp_bus.status == ST_RANGE, rsp_bus.read_color == '0 && rsp_bus.changed_count == '0, "out-of-range response carries data")
   `GFFE_ASSERT_SAME(a_ignored_zero, rsp_bus.valid && rsp_bus.status == ST_IGNORED, rsp_bus.changed_count == '0, "ignored fill reports changes")

endmodule

// File: src/gffe_ram.sv
// Generic single write port, single read port RAM with registered read data.
module gffe_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/gffe_dp.sv
// Datapath of the flood fill engine: grid, visited map, work queue and result registers.
module gffe_dp import gffe_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [FIELD_W-1:0]  req_col_x,
   input  logic [FIELD_W-1:0]  req_row_y,
   input  logic [COLOR_W-1:0]  req_color,
   output logic [COLOR_W-1:0]  rsp_read_color,
   output logic [COUNT_W-1:0]  rsp_changed_count,
   output logic [STATUS_W-1:0] rsp_status
);

   logic [FUNC_W-1:0]   func_ff;
   logic [FIELD_W-1:0]  col_ff;
   logic [FIELD_W-1:0]  row_ff;
   logic [COLOR_W-1:0]  color_ff;
   logic [COLOR_W-1:0]  prev_ff, prev_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [STATUS_W-1:0] status_ff;
   logic [QC_W-1:0]     head_ff, head_in;
   logic [QC_W-1:0]     tail_ff, tail_in;
   cell_type            cur_ff;
   logic [1:0]          dir_ff, dir_in;
   logic                nbr_pend_ff;
   cell_type            nbr_cell_ff;
   logic                clean_pend_ff;
   logic [ADDR_W-1:0]   sweep_ff;
   logic [COLOR_W-1:0]  rsp_color_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   cell_type            seed;
   nbr_type             nbr;
   logic                hit;
   logic                cell_we, vis_we, vis_wdata, q_we;
   logic [ADDR_W-1:0]   cell_waddr, cell_raddr, vis_waddr, q_wdata;
   logic [COLOR_W-1:0]  cell_wdata, cell_rd;
   logic [QA_W-1:0]     q_waddr;
   logic [ADDR_W-1:0]   q_rd;
   logic                vis_rd;

   assign seed = '{y: to_coord(row_ff), x: to_coord(col_ff)};
   assign nbr = neighbor(cur_ff, dir_ff);
   assign hit = nbr_pend_ff && !vis_rd && (cell_rd == prev_ff);

   assign sts.sweep_last = &sweep_ff;
   assign sts.in_range = (int'(col_ff) < GRID_SIZE) && (int'(row_ff) < GRID_SIZE);
   assign sts.func = func_ff;
   assign sts.prev_diff = (cell_rd != color_ff);
   assign sts.fill_ok = (cell_rd != color_ff) && (color_ff != '0);
   assign sts.q_empty = (head_ff == tail_ff);
   assign sts.dir_last = (dir_ff == DIR_DOWN);

   always_comb begin
      cell_raddr = cmd.load_req ? {to_coord(req_row_y), to_coord(req_col_x)} : nbr.pos;

      cell_we = cmd.sweep || cmd.write_cell || cmd.load_cur;
      cell_wdata = cmd.sweep ? '0 : color_ff;
      if (cmd.sweep) begin
         cell_waddr = sweep_ff;
      end else if (cmd.write_cell) begin
         cell_waddr = seed;
      end else begin
         cell_waddr = q_rd;
      end

      vis_we = cmd.sweep || cmd.start_fill || hit || clean_pend_ff;
      vis_wdata = cmd.start_fill || hit;
      if (cmd.sweep) begin
         vis_waddr = sweep_ff;
      end else if (cmd.start_fill) begin
         vis_waddr = seed;
      end else if (hit) begin
         vis_waddr = nbr_cell_ff;
      end else begin
         vis_waddr = q_rd;
      end

      q_we = cmd.start_fill || hit;
      q_waddr = cmd.start_fill ? '0 : tail_ff[QA_W-1:0];
      q_wdata = cmd.start_fill ? seed : nbr_cell_ff;
   end

   always_comb begin
      prev_in = prev_ff;
      if (cmd.take_prev) begin
         prev_in = sts.in_range ? cell_rd : '0;
      end

      count_in = count_ff;
      if (cmd.load_req) begin
         count_in = '0;
      end else if (cmd.write_cell) begin
         count_in = COUNT_W'(1);
      end else if (cmd.load_cur && count_ff != COUNT_MAX) begin
         count_in = count_ff + 1'b1;
      end

      head_in = head_ff;
      if (cmd.start_fill || cmd.clean_start) begin
         head_in = '0;
      end else if (cmd.pop || cmd.clean_rd) begin
         head_in = head_ff + 1'b1;
      end

      tail_in = tail_ff;
      if (cmd.start_fill) begin
         tail_in = QC_W'(1);
      end else if (hit) begin
         tail_in = tail_ff + 1'b1;
      end

      dir_in = dir_ff;
      if (cmd.load_cur) begin
         dir_in = DIR_LEFT;
      end else if (cmd.nbr_issue) begin
         dir_in = dir_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         dir_ff <= DIR_LEFT;
         nbr_pend_ff <= 1'b0;
         clean_pend_ff <= 1'b0;
         sweep_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         dir_ff <= dir_in;
         nbr_pend_ff <= cmd.nbr_issue && nbr.ok;
         clean_pend_ff <= cmd.clean_rd;
         if (cmd.sweep) begin
            sweep_ff <= sweep_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff <= req_func;
         col_ff <= req_col_x;
         row_ff <= req_row_y;
         color_ff <= req_color;
      end
      if (cmd.load_cur) begin
         cur_ff <= cell_type'(q_rd);
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
      if (cmd.rsp_load) begin
         rsp_color_ff <= prev_ff;
         rsp_count_ff <= count_ff;
         rsp_status_ff <= status_ff;
      end
      prev_ff <= prev_in;
      count_ff <= count_in;
      nbr_cell_ff <= nbr.pos;
   end

   gffe_ram #(.WIDTH(COLOR_W), .DEPTH(CELL_SPAN)) u_cell_ram (
      .clock   (clock),
      .wr_en   (cell_we),
      .wr_addr (cell_waddr),
      .wr_data (cell_wdata),
      .rd_addr (cell_raddr),
      .rd_data (cell_rd)
   );

   gffe_ram #(.WIDTH(1), .DEPTH(CELL_SPAN)) u_visited_ram (
      .clock   (clock),
      .wr_en   (vis_we),
      .wr_addr (vis_waddr),
      .wr_data (vis_wdata),
      .rd_addr (nbr.pos),
      .rd_data (vis_rd)
   );

   gffe_ram #(.WIDTH(ADDR_W), .DEPTH(CELL_COUNT)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_addr (head_ff[QA_W-1:0]),
      .rd_data (q_rd)
   );

   assign rsp_read_color = rsp_color_ff;
   assign rsp_changed_count = rsp_count_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// File: src/gffe_ctrl.sv
// Controller state machine of the flood fill engine.
module gffe_ctrl import gffe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  sts_type sts,
   output cmd_type cmd,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready
);

   typedef enum logic [3:0] {
      S_SWEEP,
      S_IDLE,
      S_READ,
      S_POP,
      S_LOAD,
      S_NBR,
      S_LAST,
      S_CLEAN,
      S_RESPOND
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd = '0;
      case (state_ff)
         S_SWEEP: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.take_prev = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status = ST_DONE;
            state_in = S_RESPOND;
            if (!sts.in_range) begin
               cmd.status = ST_RANGE;
            end else begin
               case (sts.func)
                  FUNC_WRITE: begin
                     cmd.write_cell = sts.prev_diff;
                  end
                  FUNC_FILL: begin
                     if (sts.fill_ok) begin
                        cmd.start_fill = 1'b1;
                        state_in = S_POP;
                     end else begin
                        cmd.status = ST_IGNORED;
                     end
                  end
                  FUNC_READ: begin
                     cmd.status = ST_DONE;
                  end
                  default: begin
                     cmd.status = ST_DONE;
                  end
               endcase
            end
         end
         S_POP: begin
            if (sts.q_empty) begin
               cmd.clean_start = 1'b1;
               state_in = S_CLEAN;
            end else begin
               cmd.pop = 1'b1;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.load_cur = 1'b1;
            state_in = S_NBR;
         end
         S_NBR: begin
            cmd.nbr_issue = 1'b1;
            if (sts.dir_last) begin
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            state_in = S_POP;
         end
         S_CLEAN: begin
            if (sts.q_empty) begin
               state_in = S_RESPOND;
            end else begin
               cmd.clean_rd = 1'b1;
            end
         end
         S_RESPOND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: test/tb_grid_flood_fill_engine_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the flood fill engine: directed and random beats against a predictor.
module tb_grid_flood_fill_engine_core import gffe_pkg::*; ();

   localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int RANDOM_ITEMS = 80;
   localparam int BIG_REGION = 300;

   typedef struct packed {
      logic [COLOR_W-1:0]  read_color;
      logic [COUNT_W-1:0]  changed_count;
      logic [STATUS_W-1:0] status;
   } report_type;

   class fill_scoreboard;
      logic [COLOR_W-1:0] grid [CELL_COUNT];
      report_type         expected_q[$];
      int                 mismatches;
      int                 n_write;
      int                 n_read;
      int                 n_fill;
      int                 n_ignored;
      int                 largest;

      function new();
         foreach (grid[i]) grid[i] = '0;
         mismatches = 0;
         n_write = 0;
         n_read = 0;
         n_fill = 0;
         n_ignored = 0;
         largest = 0;
      endfunction

      function int paint_region(int seed, logic [COLOR_W-1:0] target,
                                logic [COLOR_W-1:0] paint, bit apply);
         bit seen [CELL_COUNT];
         int frontier[$];
         int cur, cx, cy, nx, ny, ni, total;
         total = 0;
         foreach (seen[i]) seen[i] = 1'b0;
         frontier = {frontier, seed};
         seen[seed] = 1'b1;
         while (frontier.size() > 0) begin
            cur = frontier.pop_front();
            cx = cur % GRID_SIZE;
            cy = cur / GRID_SIZE;
            if (apply) grid[cur] = paint;
            total++;
            for (int d = 0; d < 4; d++) begin
               nx = cx;
               ny = cy;
               case (d[1:0])
                  DIR_LEFT: nx = cx - 1;
                  DIR_RIGHT: nx = cx + 1;
                  DIR_UP: ny = cy - 1;
                  default: ny = cy + 1;
               endcase
               if (nx >= 0 && nx < GRID_SIZE && ny >= 0 && ny < GRID_SIZE) begin
                  ni = ny * GRID_SIZE + nx;
                  if (!seen[ni] && grid[ni] == target) begin
                     seen[ni] = 1'b1;
                     frontier = {frontier, ni};
                  end
               end
            end
         end
         return total;
      endfunction

      function logic [COLOR_W-1:0] cell_color(int x, int y);
         return grid[y * GRID_SIZE + x];
      endfunction

      function int region_size(int x, int y);
         int idx;
         idx = y * GRID_SIZE + x;
         return paint_region(idx, grid[idx], grid[idx], 1'b0);
      endfunction

      function void note_request(logic [FUNC_W-1:0] f, logic [FIELD_W-1:0] x,
                                 logic [FIELD_W-1:0] y, logic [COLOR_W-1:0] c);
         report_type r;
         int idx, cnt;
         r = '0;
         r.status = ST_DONE;
         if (int'(x) >= GRID_SIZE || int'(y) >= GRID_SIZE) begin
            r.status = ST_RANGE;
         end else begin
            idx = int'(y) * GRID_SIZE + int'(x);
            r.read_color = grid[idx];
            if (f == FUNC_WRITE) begin
               n_write++;
               if (grid[idx] != c) begin
                  grid[idx] = c;
                  r.changed_count = COUNT_W'(1);
               end
            end else if (f == FUNC_FILL) begin
               n_fill++;
               if (c == grid[idx] || c == '0) begin
                  r.status = ST_IGNORED;
                  n_ignored++;
               end else begin
                  cnt = paint_region(idx, grid[idx], c, 1'b1);
                  if (cnt > largest) largest = cnt;
                  r.changed_count = (cnt > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(cnt);
               end
            end else begin
               n_read++;
            end
         end
         expected_q = {expected_q, r};
      endfunction

      function void check_report(report_type got);
         report_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected beat: color %0d count %0d status %0d",
                        got.read_color, got.changed_count, got.status);
            return;
         end
         want = expected_q.pop_front();
         if (got.read_color !== want.read_color || got.changed_count !== want.changed_count ||
             got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch: expected color %0d count %0d status %0d, got %0d %0d %0d",
                        want.read_color, want.changed_count, want.status,
                        got.read_color, got.changed_count, got.status);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   steady;
   int   cycles;
   fill_scoreboard board;

   gffe_req_if req_bus ();
   gffe_rsp_if rsp_bus ();

   grid_flood_fill_engine_core dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial cycles = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles.", cycles);
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      report_type got;
      bit fire;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         fire = !reset && rsp_bus.valid && rsp_bus.ready;
         got.read_color = rsp_bus.read_color;
         got.changed_count = rsp_bus.changed_count;
         got.status = rsp_bus.status;
         @(posedge clock);
         if (fire) board.check_report(got);
         rsp_bus.ready <= steady || ($urandom_range(0, 99) >= 11);
      end
   end

   task automatic send_req(logic [FUNC_W-1:0] f, int x, int y, int c);
      bit took;
      if (!steady && $urandom_range(0, 99) < 11) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.func <= f;
      req_bus.col_x <= FIELD_W'(x);
      req_bus.row_y <= FIELD_W'(y);
      req_bus.color <= COLOR_W'(c);
      do begin
         @(negedge clock);
         took = req_bus.ready;
         @(posedge clock);
      end while (!took);
      board.note_request(f, FIELD_W'(x), FIELD_W'(y), COLOR_W'(c));
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (board.expected_q.size() > 0) @(posedge clock);
   endtask

   task automatic run_directed();
      send_req(FUNC_READ, 0, 0, 0);
      send_req(FUNC_SPARE, GRID_SIZE - 1, GRID_SIZE - 1, 15);
      send_req(FUNC_FILL, 0, 0, 0);
      send_req(FUNC_WRITE, GRID_SIZE - 1, 0, 15);
      send_req(FUNC_WRITE, GRID_SIZE - 1, 0, 15);
      send_req(FUNC_WRITE, 0, GRID_SIZE - 1, 0);
      send_req(FUNC_FILL, 0, 0, 9);
      send_req(FUNC_FILL, 10, 10, 9);
      send_req(FUNC_FILL, GRID_SIZE - 1, 0, 9);
      send_req(FUNC_FILL, 32, 32, 1);
      send_req(FUNC_WRITE, 1, 0, 2);
      send_req(FUNC_WRITE, 0, 1, 2);
      send_req(FUNC_FILL, 0, 0, 3);
      send_req(FUNC_FILL, 1, 0, 4);
      send_req(FUNC_WRITE, GRID_SIZE - 2, GRID_SIZE - 1, 7);
      send_req(FUNC_WRITE, GRID_SIZE - 1, GRID_SIZE - 2, 7);
      send_req(FUNC_FILL, GRID_SIZE - 1, GRID_SIZE - 1, 15);
      send_req(FUNC_WRITE, 0, 0, 0);
      send_req(FUNC_SPARE, 0, 0, 6);
      send_req(FUNC_READ, 42, 21, 10);
   endtask

   task automatic run_random(int total);
      int base_x, base_y, x, y, c, roll, big_left;
      logic [FUNC_W-1:0] f;
      big_left = 3;
      base_x = 0;
      base_y = 0;
      for (int i = 0; i < total; i++) begin
         if (i % 16 == 0) begin
            case ($urandom_range(0, 3))
               0: begin
                  base_x = 0;
                  base_y = 0;
               end
               1: begin
                  base_x = GRID_SIZE - 8;
                  base_y = GRID_SIZE - 8;
               end
               default: begin
                  base_x = $urandom_range(0, GRID_SIZE - 8);
                  base_y = $urandom_range(0, GRID_SIZE - 8);
               end
            endcase
         end
         if (i == 40) wait_drained();
         steady = (i >= 55 && i < 80);
         x = base_x + $urandom_range(0, 7);
         y = base_y + $urandom_range(0, 7);
         roll = $urandom_range(0, 99);
         if (roll < 50) begin
            f = FUNC_WRITE;
            c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(2, 3);
            if ($urandom_range(0, 9) == 0) begin
               x = $urandom_range(0, GRID_SIZE - 1);
               y = $urandom_range(0, GRID_SIZE - 1);
            end
         end else if (roll < 70) begin
            f = ($urandom_range(0, 4) == 0) ? FUNC_SPARE : FUNC_READ;
            c = $urandom_range(0, 15);
            if (roll < 60) begin
               x = $urandom_range(0, GRID_SIZE - 1);
               y = $urandom_range(0, GRID_SIZE - 1);
            end
         end else begin
            f = FUNC_FILL;
            c = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 15);
            if (c != 0 && c != board.cell_color(x, y) &&
                board.region_size(x, y) > BIG_REGION) begin
               if (big_left > 0) big_left--;
               else c = board.cell_color(x, y);
            end
         end
         send_req(f, x, y, c);
      end
      steady = 1'b0;
   endtask

   initial begin
      board = new();
      steady = 1'b0;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.func <= FUNC_READ;
      req_bus.col_x <= '0;
      req_bus.row_y <= '0;
      req_bus.color <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random(RANDOM_ITEMS);
      wait_drained();
      repeat (50) @(posedge clock);
      $display("Run covered %0d writes, %0d reads and %0d fills, %0d of the fills ignored.",
               board.n_write, board.n_read, board.n_fill, board.n_ignored);
      $display("Largest fill repainted %0d cells; %0d mismatches, %0d beats missing.",
               board.largest, board.mismatches, board.expected_q.size());
      if (board.mismatches == 0 && board.expected_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+src
src/gffe_pkg.sv
src/gffe_ifs.sv
src/gffe_ram.sv
src/gffe_dp.sv
src/gffe_ctrl.sv
src/grid_flood_fill_engine_core.sv
test/tb_grid_flood_fill_engine_core.sv
